// ----- rtl/fstp_pkg.sv -----
// Shared types, codes and helper function of the field strength tap profiler.
package fstp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MV_WIDTH    = 12;
    localparam logic [11:0] MV_FULL = 12'd3600;
    localparam logic [15:0] THRESHOLD_RESET = 16'd600;

    localparam logic [2:0] MODE_SAMPLE = 3'd0;
    localparam logic [2:0] MODE_MISS   = 3'd1;
    localparam logic [2:0] MODE_UP     = 3'd2;
    localparam logic [2:0] MODE_LOST   = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    typedef enum logic [2:0] {
        OP_SAMPLE,
        OP_MISS,
        OP_UP,
        OP_LOST,
        OP_CLEAR,
        OP_NONE
    } fstp_op_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic [31:0]        now_ms;
        logic signed [15:0] raw_adc;
    } fstp_in_t;

    typedef struct packed {
        logic [31:0] field_appearances;
        logic [31:0] frames_sent;
        logic [31:0] session_ms_longest;
        logic [31:0] strong_ms_longest;
        logic [11:0] last_mv;
        logic [11:0] peak_mv;
        logic [15:0] sample_count;
        logic [15:0] strong_count;
        logic [15:0] strong_run_longest;
        logic [15:0] missed_count;
        logic        emulating;
        logic        clipped;
    } fstp_out_t;

    // One classified transaction as it travels from the front to the back.
    typedef struct packed {
        fstp_op_t    op;
        logic [31:0] now_ms;
        logic [11:0] mv;
        logic        clip;
    } fstp_work_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } fstp_qstat_t;

    function automatic logic [15:0] inc_sat16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

// ----- rtl/fstp_front.sv -----
// Front end: accepts input transactions, decodes the mode and converts the sample to mV.
module fstp_front #(
    parameter int ADC_BITS = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  fstp_pkg::fstp_in_t  in_item,
    input  fstp_pkg::fstp_qstat_t qstat,
    output logic                push,
    output fstp_pkg::fstp_work_t push_item
);
    import fstp_pkg::*;

    localparam logic [16:0] FULL_M1 = 17'((1 << ADC_BITS) - 1);
    localparam int PROD_W = ADC_BITS + MV_WIDTH;

    logic                 valid_reg;
    fstp_work_t           work_reg;
    fstp_work_t           work_next;
    logic [16:0]          raw_pos;
    logic                 clip;
    logic [ADC_BITS-1:0]  raw_clamped;
    logic [PROD_W-1:0]    product;
    logic                 load;

    always_comb
    begin
        // A negative reading counts as zero.
        raw_pos = in_item.raw_adc[15] ? 17'd0 : {2'b00, in_item.raw_adc[14:0]};
        clip = (raw_pos >= FULL_M1);
        raw_clamped = clip ? FULL_M1[ADC_BITS-1:0] : raw_pos[ADC_BITS-1:0];
        product = PROD_W'(raw_clamped) * PROD_W'(MV_FULL);

        work_next.now_ms = in_item.now_ms;
        work_next.mv     = product[ADC_BITS +: MV_WIDTH];
        work_next.clip   = clip;
        unique case (in_item.mode)
            MODE_SAMPLE: work_next.op = OP_SAMPLE;
            MODE_MISS:   work_next.op = OP_MISS;
            MODE_UP:     work_next.op = OP_UP;
            MODE_LOST:   work_next.op = OP_LOST;
            MODE_CLEAR:  work_next.op = OP_CLEAR;
            default:     work_next.op = OP_NONE;
        endcase
    end

    assign push     = valid_reg && !qstat.full;
    assign in_stall = valid_reg && qstat.full;
    assign load     = in_valid && !in_stall;
    assign push_item = work_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            work_reg <= work_next;
        end
    end

endmodule

// ----- rtl/fstp_queue.sv -----
// Short queue that decouples the front end from the statistics back end.
module fstp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  fstp_pkg::fstp_work_t  push_item,
    input  logic                  pop,
    output fstp_pkg::fstp_work_t  head_item,
    output fstp_pkg::fstp_qstat_t qstat
);
    import fstp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    fstp_work_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign qstat.full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign qstat.nonempty = (count_reg != '0);
    assign head_item      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && qstat.full))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !qstat.nonempty))
        else $error("pop from an empty queue");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count did not follow a push");

endmodule

// ----- rtl/fstp_back.sv -----
// Back end: updates the field statistics and holds the snapshot for the output channel.
module fstp_back #(
    parameter int BURST_FRAMES = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [15:0]           cfg_data,
    input  fstp_pkg::fstp_qstat_t qstat,
    input  fstp_pkg::fstp_work_t  head_item,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output fstp_pkg::fstp_out_t   out_item
);
    import fstp_pkg::*;

    logic [15:0] threshold_reg;
    logic [31:0] appear_reg,        appear_next;
    logic [31:0] frames_reg,        frames_next;
    logic [31:0] session_max_reg,   session_max_next;
    logic [31:0] session_start_reg, session_start_next;
    logic [31:0] hold_max_reg,      hold_max_next;
    logic [31:0] hold_start_reg,    hold_start_next;
    logic [11:0] latest_reg,        latest_next;
    logic [11:0] highest_reg,       highest_next;
    logic [15:0] samples_reg,       samples_next;
    logic [15:0] strong_reg,        strong_next;
    logic [15:0] run_reg,           run_next;
    logic [15:0] run_longest_reg,   run_longest_next;
    logic [15:0] misses_reg,        misses_next;
    logic        active_reg,        active_next;
    logic        clip_reg,          clip_next;
    logic        out_valid_reg;
    fstp_out_t   out_item_reg,      out_item_next;

    logic [31:0] now;
    logic [31:0] held_cur;
    logic [31:0] sess_cur;
    logic [31:0] hold_open;
    logic [31:0] sess_open;
    logic        hold_restart;
    logic        sess_restart;
    logic        is_strong;

    assign pop       = qstat.nonempty && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        now      = head_item.now_ms;
        held_cur = now - hold_start_reg;
        sess_cur = now - session_start_reg;
        is_strong = ({4'd0, head_item.mv} >= threshold_reg);

        appear_next        = appear_reg;
        frames_next        = frames_reg;
        session_max_next   = session_max_reg;
        session_start_next = session_start_reg;
        hold_max_next      = hold_max_reg;
        hold_start_next    = hold_start_reg;
        latest_next        = latest_reg;
        highest_next       = highest_reg;
        samples_next       = samples_reg;
        strong_next        = strong_reg;
        run_next           = run_reg;
        run_longest_next   = run_longest_reg;
        misses_next        = misses_reg;
        active_next        = active_reg;
        clip_next          = clip_reg;
        hold_restart       = 1'b0;
        sess_restart       = 1'b0;

        unique case (head_item.op)
            OP_SAMPLE:
            begin
                if (active_reg)
                begin
                    frames_next  = frames_reg + 32'(BURST_FRAMES);
                    clip_next    = clip_reg | head_item.clip;
                    latest_next  = head_item.mv;
                    if (head_item.mv > highest_reg)
                    begin
                        highest_next = head_item.mv;
                    end
                    samples_next = inc_sat16(samples_reg);
                    if (is_strong)
                    begin
                        strong_next = inc_sat16(strong_reg);
                        run_next    = inc_sat16(run_reg);
                        if (run_next > run_longest_reg)
                        begin
                            run_longest_next = run_next;
                        end
                        if (run_reg == 16'd0)
                        begin
                            // A new strong run starts timing its hold here.
                            hold_start_next = now;
                            hold_restart    = 1'b1;
                        end
                        else if (held_cur > hold_max_reg)
                        begin
                            hold_max_next = held_cur;
                        end
                    end
                    else
                    begin
                        run_next = 16'd0;
                    end
                end
            end
            OP_MISS:
            begin
                if (active_reg)
                begin
                    frames_next = frames_reg + 32'(BURST_FRAMES);
                    misses_next = inc_sat16(misses_reg);
                end
            end
            OP_UP:
            begin
                if (!active_reg)
                begin
                    if (appear_reg != 32'hFFFF_FFFF)
                    begin
                        appear_next = appear_reg + 32'd1;
                    end
                    session_start_next = now;
                    sess_restart       = 1'b1;
                    run_next           = 16'd0;
                    active_next        = 1'b1;
                end
            end
            OP_LOST:
            begin
                if (active_reg)
                begin
                    if (sess_cur > session_max_reg)
                    begin
                        session_max_next = sess_cur;
                    end
                    if (run_reg != 16'd0 && held_cur > hold_max_reg)
                    begin
                        hold_max_next = held_cur;
                    end
                    run_next    = 16'd0;
                    active_next = 1'b0;
                end
            end
            OP_CLEAR:
            begin
                // An open session stays open but its clock restarts.
                appear_next        = 32'd0;
                frames_next        = 32'd0;
                session_max_next   = 32'd0;
                hold_max_next      = 32'd0;
                latest_next        = 12'd0;
                highest_next       = 12'd0;
                samples_next       = 16'd0;
                strong_next        = 16'd0;
                run_next           = 16'd0;
                run_longest_next   = 16'd0;
                misses_next        = 16'd0;
                clip_next          = 1'b0;
                session_start_next = now;
                sess_restart       = 1'b1;
            end
            default:
            begin
            end
        endcase

        sess_open = sess_restart ? 32'd0 : sess_cur;
        hold_open = hold_restart ? 32'd0 : held_cur;

        out_item_next.field_appearances  = appear_next;
        out_item_next.frames_sent        = frames_next;
        out_item_next.session_ms_longest =
            (active_next && sess_open > session_max_next) ? sess_open : session_max_next;
        out_item_next.strong_ms_longest  =
            (active_next && run_next != 16'd0 && hold_open > hold_max_next)
                ? hold_open : hold_max_next;
        out_item_next.last_mv            = latest_next;
        out_item_next.peak_mv            = highest_next;
        out_item_next.sample_count       = samples_next;
        out_item_next.strong_count       = strong_next;
        out_item_next.strong_run_longest = run_longest_next;
        out_item_next.missed_count       = misses_next;
        out_item_next.emulating          = active_next;
        out_item_next.clipped            = clip_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg     <= THRESHOLD_RESET;
            appear_reg        <= '0;
            frames_reg        <= '0;
            session_max_reg   <= '0;
            session_start_reg <= '0;
            hold_max_reg      <= '0;
            hold_start_reg    <= '0;
            latest_reg        <= '0;
            highest_reg       <= '0;
            samples_reg       <= '0;
            strong_reg        <= '0;
            run_reg           <= '0;
            run_longest_reg   <= '0;
            misses_reg        <= '0;
            active_reg        <= 1'b0;
            clip_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                threshold_reg <= cfg_data;
            end
            if (pop)
            begin
                appear_reg        <= appear_next;
                frames_reg        <= frames_next;
                session_max_reg   <= session_max_next;
                session_start_reg <= session_start_next;
                hold_max_reg      <= hold_max_next;
                hold_start_reg    <= hold_start_next;
                latest_reg        <= latest_next;
                highest_reg       <= highest_next;
                samples_reg       <= samples_next;
                strong_reg        <= strong_next;
                run_reg           <= run_next;
                run_longest_reg   <= run_longest_next;
                misses_reg        <= misses_next;
                active_reg        <= active_next;
                clip_reg          <= clip_next;
                out_valid_reg     <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

// ----- rtl/field_strength_tap_profiler.sv -----
// Top level of the field strength tap profiler.
//
// Input channel: in_valid / in_stall / in_item carry one event transaction
// (mode, now_ms, raw_adc). A transaction is taken at a rising edge where
// in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall / out_item carry one statistics
// snapshot for every input transaction, in order.
// Configuration: cfg_valid / cfg_ready / cfg_data write the strong threshold
// in mV; cfg_ready is always high. Write it only while the block is idle.
// Path: a snapshot passes through the front register, the four-entry queue
// and the output register before it shows on out_item.
// Throughput: one transaction per cycle while the receiver does not stall;
// the back end updates the statistics as it pops each transaction.
// Reset clears all statistics, closes any session and sets the threshold to
// 600 mV. When the receiver stalls, the output register holds; the queue
// fills and only then does in_stall rise.
module field_strength_tap_profiler #(
    parameter int BURST_FRAMES = 10,
    parameter int ADC_BITS     = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  fstp_pkg::fstp_in_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output fstp_pkg::fstp_out_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);
    import fstp_pkg::*;

    fstp_qstat_t qstat;
    fstp_work_t  push_item;
    fstp_work_t  head_item;
    logic        push;
    logic        pop;

    assign cfg_ready = 1'b1;

    fstp_front #(
        .ADC_BITS(ADC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .qstat     (qstat),
        .push      (push),
        .push_item (push_item)
    );

    fstp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .qstat     (qstat)
    );

    fstp_back #(
        .BURST_FRAMES(BURST_FRAMES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .qstat     (qstat),
        .head_item (head_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// ----- sim/field_strength_tap_profiler_tb.sv -----
// Self-checking testbench for the field strength tap profiler: directed table, random sessions.
module field_strength_tap_profiler_tb;
    import fstp_pkg::*;

    localparam int BURST_FRAMES = 10;
    localparam int ADC_BITS     = 14;
    localparam int FULL_CODE    = (1 << ADC_BITS) - 1;
    localparam int MV_SCALE     = 3600;
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 120;
    localparam int PHASE_ITEMS  = 330;

    typedef enum logic [1:0] {
        EXP_PREDICT,
        EXP_ZERO,
        EXP_OPENED
    } exp_kind_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] now_ms;
        logic [15:0] raw;
        exp_kind_t   want;
    } plan_row_t;

    localparam plan_row_t DIRECTED [24] = '{
        '{MODE_SAMPLE,   32'd0,          16'h7FFF, EXP_ZERO},
        '{MODE_LOST,     32'hFFFF_FFFF,  16'h0000, EXP_ZERO},
        '{MODE_MISS,     32'd7,          16'h8000, EXP_ZERO},
        '{MODE_SPARE_LO, 32'd9,          16'h1234, EXP_ZERO},
        '{MODE_UP,       32'd1000,       16'h0000, EXP_OPENED},
        '{MODE_UP,       32'd1500,       16'h0000, EXP_PREDICT},
        '{MODE_SAMPLE,   32'd1600,       16'h8000, EXP_PREDICT},
        '{MODE_SAMPLE,   32'd1700,       16'd2730, EXP_PREDICT},
        '{MODE_SAMPLE,   32'd1800,       16'd2731, EXP_PREDICT},
        '{MODE_SAMPLE,   32'd1900,       16'd16382, EXP_PREDICT},
        '{MODE_SAMPLE,   32'd2000,       16'd16383, EXP_PREDICT},
        '{MODE_SAMPLE,   32'd2100,       16'h7FFF, EXP_PREDICT},
        '{MODE_MISS,     32'd2200,       16'h0000, EXP_PREDICT},
        '{MODE_SAMPLE,   32'd2300,       16'hFFFF, EXP_PREDICT},
        '{MODE_LOST,     32'd2500,       16'h0000, EXP_PREDICT},
        '{MODE_SPARE_HI, 32'd2600,       16'hFFFF, EXP_PREDICT},
        '{MODE_SAMPLE,   32'd2700,       16'd16383, EXP_PREDICT},
        '{MODE_UP,       32'hFFFF_FFF0,  16'h0000, EXP_PREDICT},
        '{MODE_SAMPLE,   32'hFFFF_FFF8,  16'h3FFF, EXP_PREDICT},
        '{MODE_SAMPLE,   32'h0000_0010,  16'h2000, EXP_PREDICT},
        '{MODE_CLEAR,    32'h0000_0020,  16'h0000, EXP_PREDICT},
        '{MODE_SAMPLE,   32'h0000_0030,  16'h1000, EXP_PREDICT},
        '{MODE_LOST,     32'hFFFF_FFFF,  16'h0000, EXP_PREDICT},
        '{MODE_CLEAR,    32'd0,          16'h0000, EXP_ZERO}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    fstp_in_t    in_item;
    logic        out_valid;
    logic        out_stall;
    fstp_out_t   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    field_strength_tap_profiler #(
        .BURST_FRAMES(BURST_FRAMES),
        .ADC_BITS    (ADC_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Profile state mirrored by the predictor.
    logic [15:0] threshold_mv;
    logic [31:0] appearances;
    logic [31:0] frame_tally;
    logic [31:0] session_best;
    logic [31:0] session_t0;
    logic [31:0] hold_best;
    logic [31:0] hold_t0;
    logic [11:0] recent_mv;
    logic [11:0] top_mv;
    logic [15:0] sample_tally;
    logic [15:0] strong_tally;
    logic [15:0] run_now;
    logic [15:0] run_best;
    logic [15:0] miss_tally;
    logic        in_session;
    logic        clip_flag;

    fstp_out_t   expected_snaps[$];
    fstp_out_t   head_snap;
    logic [31:0] clock_ms;
    int          errors;
    int          quiet_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        hold_off;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [15:0] bump16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    task automatic clear_profile();
        appearances  = '0;
        frame_tally  = '0;
        session_best = '0;
        hold_best    = '0;
        recent_mv    = '0;
        top_mv       = '0;
        sample_tally = '0;
        strong_tally = '0;
        run_now      = '0;
        run_best     = '0;
        miss_tally   = '0;
        clip_flag    = 1'b0;
    endtask

    // Folds one event into the mirrored profile and returns the snapshot it yields.
    task automatic profile_event(input fstp_in_t ev, output fstp_out_t snap);
        logic [15:0] raw_bits;
        logic [31:0] code;
        logic [31:0] scaled;
        logic [11:0] mv;
        logic [31:0] span;
        raw_bits = ev.raw_adc;
        if (ev.mode == MODE_SAMPLE && in_session)
        begin
            frame_tally = frame_tally + 32'(BURST_FRAMES);
            code = raw_bits[15] ? 32'd0 : {17'd0, raw_bits[14:0]};
            if (code >= 32'(FULL_CODE))
            begin
                clip_flag = 1'b1;
                code = 32'(FULL_CODE);
            end
            scaled = (code * 32'(MV_SCALE)) >> ADC_BITS;
            mv = scaled[11:0];
            recent_mv = mv;
            if (mv > top_mv)
                top_mv = mv;
            sample_tally = bump16(sample_tally);
            if ({4'd0, mv} >= threshold_mv)
            begin
                strong_tally = bump16(strong_tally);
                run_now = bump16(run_now);
                if (run_now > run_best)
                    run_best = run_now;
                if (run_now == 16'd1)
                begin
                    hold_t0 = ev.now_ms;
                end
                else
                begin
                    span = ev.now_ms - hold_t0;
                    if (span > hold_best)
                        hold_best = span;
                end
            end
            else
            begin
                run_now = '0;
            end
        end
        else if (ev.mode == MODE_MISS && in_session)
        begin
            frame_tally = frame_tally + 32'(BURST_FRAMES);
            miss_tally = bump16(miss_tally);
        end
        else if (ev.mode == MODE_UP && !in_session)
        begin
            if (appearances != 32'hFFFF_FFFF)
                appearances = appearances + 32'd1;
            session_t0 = ev.now_ms;
            run_now = '0;
            in_session = 1'b1;
        end
        else if (ev.mode == MODE_LOST && in_session)
        begin
            span = ev.now_ms - session_t0;
            if (span > session_best)
                session_best = span;
            if (run_now != 16'd0)
            begin
                span = ev.now_ms - hold_t0;
                if (span > hold_best)
                    hold_best = span;
            end
            run_now = '0;
            in_session = 1'b0;
        end
        else if (ev.mode == MODE_CLEAR)
        begin
            clear_profile();
            session_t0 = ev.now_ms;
        end

        snap.session_ms_longest = session_best;
        snap.strong_ms_longest  = hold_best;
        if (in_session)
        begin
            span = ev.now_ms - session_t0;
            if (span > session_best)
                snap.session_ms_longest = span;
            span = ev.now_ms - hold_t0;
            if (run_now != 16'd0 && span > hold_best)
                snap.strong_ms_longest = span;
        end
        snap.field_appearances  = appearances;
        snap.frames_sent        = frame_tally;
        snap.last_mv            = recent_mv;
        snap.peak_mv            = top_mv;
        snap.sample_count       = sample_tally;
        snap.strong_count       = strong_tally;
        snap.strong_run_longest = run_best;
        snap.missed_count       = miss_tally;
        snap.emulating          = in_session;
        snap.clipped            = clip_flag;
    endtask

    // Presents one transaction and returns at the edge that takes it.
    task automatic offer(input fstp_in_t ev);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= ev;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic emit(input fstp_in_t ev);
        fstp_out_t snap;
        offer(ev);
        profile_event(ev, snap);
        expected_snaps.push_back(snap);
    endtask

    // Advances the millisecond clock and picks a reading, often close to the threshold.
    function automatic fstp_in_t next_event(input logic [2:0] mode);
        fstp_in_t ev;
        int       near;
        if ($urandom_range(99) < 3)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, 400);
        ev.mode   = mode;
        ev.now_ms = clock_ms;
        case ($urandom_range(4))
            0: ev.raw_adc = 16'($urandom);
            1: ev.raw_adc = 16'($urandom_range(0, FULL_CODE));
            2: ev.raw_adc = 16'($urandom_range(FULL_CODE - 3, FULL_CODE + 3));
            default:
            begin
                if (int'(threshold_mv) < MV_SCALE)
                begin
                    near = (int'(threshold_mv) << ADC_BITS) / MV_SCALE
                           + int'($urandom_range(0, 6)) - 3;
                    ev.raw_adc = 16'((near < 0) ? 0 : near);
                end
                else
                begin
                    ev.raw_adc = 16'($urandom_range(0, FULL_CODE));
                end
            end
        endcase
        return ev;
    endfunction

    // Mostly complete sessions with random content, plus clears and stray events.
    task automatic random_traffic(input int n_items);
        int sent;
        int pick;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                emit(next_event(MODE_UP));
                sent++;
                repeat ($urandom_range(1, 12))
                begin
                    if ($urandom_range(99) < 5)
                        emit(next_event(3'($urandom_range(7))));
                    else if ($urandom_range(99) < 85)
                        emit(next_event(MODE_SAMPLE));
                    else
                        emit(next_event(MODE_MISS));
                    sent++;
                end
                // Now and then a session is left open so the next field-up is ignored.
                if ($urandom_range(99) < 90)
                begin
                    emit(next_event(MODE_LOST));
                    sent++;
                end
            end
            else if (pick < 86)
            begin
                emit(next_event(MODE_CLEAR));
                sent++;
            end
            else
            begin
                emit(next_event(3'($urandom_range(7))));
                sent++;
            end
        end
    endtask

    task automatic write_threshold(input logic [15:0] value);
        while (expected_snaps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        threshold_mv = value;
    endtask

    task automatic run_phase(input logic [15:0] thr, input int s_pct, input int r_pct,
                             input bit squeeze);
        write_threshold(thr);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        if (squeeze)
        begin
            fork
                begin
                    hold_off <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_off <= 1'b0;
                end
            join_none
        end
        random_traffic(PHASE_ITEMS);
        in_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_snaps.size() == 0)
            begin
                errors++;
                $display("%0t: snapshot with none expected, got %p", $time, out_item);
            end
            else
            begin
                head_snap = expected_snaps.pop_front();
                check_field("field_appearances", head_snap.field_appearances,
                            out_item.field_appearances);
                check_field("frames_sent", head_snap.frames_sent, out_item.frames_sent);
                check_field("session_ms_longest", head_snap.session_ms_longest,
                            out_item.session_ms_longest);
                check_field("strong_ms_longest", head_snap.strong_ms_longest,
                            out_item.strong_ms_longest);
                check_field("last_mv", 32'(head_snap.last_mv), 32'(out_item.last_mv));
                check_field("peak_mv", 32'(head_snap.peak_mv), 32'(out_item.peak_mv));
                check_field("sample_count", 32'(head_snap.sample_count),
                            32'(out_item.sample_count));
                check_field("strong_count", 32'(head_snap.strong_count),
                            32'(out_item.strong_count));
                check_field("strong_run_longest", 32'(head_snap.strong_run_longest),
                            32'(out_item.strong_run_longest));
                check_field("missed_count", 32'(head_snap.missed_count),
                            32'(out_item.missed_count));
                check_field("emulating", 32'(head_snap.emulating), 32'(out_item.emulating));
                check_field("clipped", 32'(head_snap.clipped), 32'(out_item.clipped));
            end
        end
    end

    // Ends a run in which no transaction has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        fstp_in_t  ev;
        fstp_out_t snap;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_item       = '0;
        out_stall     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        hold_off      = 1'b0;
        errors        = 0;
        quiet_cycles  = 0;
        clock_ms      = $urandom;
        send_idle_pct = 35;
        recv_idle_pct = 64;
        threshold_mv  = THRESHOLD_RESET;
        clear_profile();
        session_t0    = '0;
        hold_t0       = '0;
        in_session    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            ev.mode    = DIRECTED[i].mode;
            ev.now_ms  = DIRECTED[i].now_ms;
            ev.raw_adc = DIRECTED[i].raw;
            offer(ev);
            profile_event(ev, snap);
            case (DIRECTED[i].want)
                EXP_ZERO: snap = '0;
                EXP_OPENED:
                begin
                    snap = '0;
                    snap.field_appearances = 32'd1;
                    snap.emulating         = 1'b1;
                end
                default: ;
            endcase
            expected_snaps.push_back(snap);
        end
        in_valid <= 1'b0;

        run_phase(16'd0, 35, 64, 1'b0);
        run_phase(16'hFFFF, 35, 64, 1'b0);
        run_phase(16'd1800, 64, 35, 1'b0);
        run_phase(16'($urandom), 64, 35, 1'b0);
        run_phase(16'($urandom_range(1, MV_SCALE - 1)), 0, 0, 1'b1);
        run_phase(THRESHOLD_RESET, 0, 0, 1'b0);

        while (expected_snaps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- field_strength_tap_profiler.f -----
rtl/fstp_pkg.sv
rtl/fstp_front.sv
rtl/fstp_queue.sv
rtl/fstp_back.sv
rtl/field_strength_tap_profiler.sv
sim/field_strength_tap_profiler_tb.sv
